FILE: hw/rtl/rtdq_pkg.sv
// ----------------------------------------------------------------------------
// rtdq_pkg
// shared types, codes and defaults for the release and deadline task queue
// ----------------------------------------------------------------------------
package rtdq_pkg;

    localparam int TIME_BITS      = 63;
    localparam int OUT_ID_BITS    = 16;
    localparam int MOVE_BITS      = 8;
    localparam int HEAP_DEPTH_DEF = 256;
    localparam int ID_BITS_DEF    = 16;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        HOP_PUSH = 2'd0,
        HOP_POP  = 2'd1,
        HOP_PEEK = 2'd2
    } heap_op_t;

    typedef struct packed {
        logic     valid;
        heap_op_t op;
    } heap_cmd_t;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [OUT_ID_BITS-1:0] task_id;
        logic [TIME_BITS-1:0]   release_time;
        logic [TIME_BITS-1:0]   deadline;
        logic [TIME_BITS-1:0]   now_time;
    } in_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [OUT_ID_BITS-1:0] out_task_id;
        logic [TIME_BITS-1:0]   out_deadline;
        logic [MOVE_BITS-1:0]   moved_count;
    } out_t;

endpackage

FILE: hw/rtl/rtdq_heap.sv
// ----------------------------------------------------------------------------
// rtdq_heap
// binary min-heap in a synchronous memory: push, pop root and peek root
// ----------------------------------------------------------------------------
module rtdq_heap #(
    parameter int DEPTH = rtdq_pkg::HEAP_DEPTH_DEF,
    parameter int DW    = 2 * rtdq_pkg::TIME_BITS,
    parameter int KW    = rtdq_pkg::TIME_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rtdq_pkg::heap_cmd_t       cmd,
    input  logic [DW-1:0]             push_data,
    output logic                      done,
    output logic [DW-1:0]             root,
    output logic [$clog2(DEPTH):0]    count
);
    import rtdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    typedef enum logic [6:0] {
        H_IDLE   = 7'b0000001,
        H_UP_RD  = 7'b0000010,
        H_UP_CMP = 7'b0000100,
        H_PEEK   = 7'b0001000,
        H_POP_LD = 7'b0010000,
        H_DN_RD  = 7'b0100000,
        H_DN_CMP = 7'b1000000
    } hstate_t;

    logic [DW-1:0] mem [DEPTH];

    hstate_t       state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] x_reg, x_next;
    logic [DW-1:0] root_reg, root_next;
    logic          done_reg, done_next;
    logic [DW-1:0] rd0_reg, rd1_reg;

    logic [AW-1:0] raddr0, raddr1, waddr;
    logic [DW-1:0] wdata;
    logic          we;

    logic [AW-1:0] idx_dec, parent;
    logic [AW+1:0] lchild, rchild;
    logic          l_ok, r_ok, take_l, take_r;
    logic [KW-1:0] best_key;

    function automatic logic [AW-1:0] idx_dec_cnt(input logic [CW-1:0] c);
        logic [CW-1:0] d;
        d = c - CW'(1);
        return d[AW-1:0];
    endfunction

    assign idx_dec  = idx_reg - AW'(1);
    assign parent   = {1'b0, idx_dec[AW-1:1]};
    assign lchild   = {1'b0, idx_reg, 1'b1};
    assign rchild   = lchild + (AW+2)'(1);
    assign l_ok     = lchild < {1'b0, cnt_reg};
    assign r_ok     = rchild < {1'b0, cnt_reg};
    assign take_l   = l_ok && (x_reg[KW-1:0] > rd0_reg[KW-1:0]);
    assign best_key = take_l ? rd0_reg[KW-1:0] : x_reg[KW-1:0];
    assign take_r   = r_ok && (best_key > rd1_reg[KW-1:0]);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = x_reg;
        raddr0     = '0;
        raddr1     = '0;
        case (state_reg)
            H_IDLE: begin
                if (cmd.valid) begin
                    case (cmd.op)
                        HOP_PUSH: begin
                            x_next     = push_data;
                            idx_next   = cnt_reg[AW-1:0];
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = H_UP_RD;
                        end
                        HOP_POP: begin
                            raddr1     = idx_dec_cnt(cnt_reg);
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = H_POP_LD;
                        end
                        HOP_PEEK: begin
                            state_next = H_PEEK;
                        end
                        default: begin
                            state_next = H_IDLE;
                        end
                    endcase
                end
            end
            H_UP_RD: begin
                if (idx_reg == '0) begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end else begin
                    raddr0     = parent;
                    state_next = H_UP_CMP;
                end
            end
            H_UP_CMP: begin
                we = 1'b1;
                if (rd0_reg[KW-1:0] > x_reg[KW-1:0]) begin
                    wdata      = rd0_reg;
                    idx_next   = parent;
                    state_next = H_UP_RD;
                end else begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            H_PEEK: begin
                root_next  = rd0_reg;
                done_next  = 1'b1;
                state_next = H_IDLE;
            end
            H_POP_LD: begin
                root_next = rd0_reg;
                x_next    = rd1_reg;
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end else begin
                    idx_next   = '0;
                    state_next = H_DN_RD;
                end
            end
            H_DN_RD: begin
                raddr0     = lchild[AW-1:0];
                raddr1     = rchild[AW-1:0];
                state_next = H_DN_CMP;
            end
            H_DN_CMP: begin
                we = 1'b1;
                if (take_r) begin
                    wdata      = rd1_reg;
                    idx_next   = rchild[AW-1:0];
                    state_next = H_DN_RD;
                end else if (take_l) begin
                    wdata      = rd0_reg;
                    idx_next   = lchild[AW-1:0];
                    state_next = H_DN_RD;
                end else begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default: begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        idx_reg  <= idx_next;
        x_reg    <= x_next;
        root_reg <= root_next;
    end

    assign done  = done_reg;
    assign root  = root_reg;
    assign count = cnt_reg;

endmodule

FILE: hw/rtl/release_and_deadline_task_queue_core.sv
// insert: the new task climbs level by level, one parent read and compare per level
// pop: the last task sinks level by level, two child reads and compares per level
// update: per moved task, a wait-heap peek and pop and a ready-heap push
// one request at a time; the result register frees the next request while it waits
// synchronous active-low reset empties both heaps; memory contents are not cleared
// ----------------------------------------------------------------------------
// release_and_deadline_task_queue_core
// wait heap keyed by release time, ready heap keyed by deadline
// ----------------------------------------------------------------------------
module release_and_deadline_task_queue_core #(
    parameter int HEAP_DEPTH = rtdq_pkg::HEAP_DEPTH_DEF,
    parameter int ID_BITS    = rtdq_pkg::ID_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rtdq_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rtdq_pkg::out_t m_data
);
    import rtdq_pkg::*;

    localparam int CW     = $clog2(HEAP_DEPTH) + 1;
    localparam int WDW    = ID_BITS + 2 * TIME_BITS;
    localparam int RDW    = ID_BITS + TIME_BITS;
    localparam logic [CW-1:0] FULL_LVL = CW'(HEAP_DEPTH - 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b00000001,
        S_INS      = 8'b00000010,
        S_UPD_CHK  = 8'b00000100,
        S_UPD_PK   = 8'b00001000,
        S_UPD_POP  = 8'b00010000,
        S_UPD_PUSH = 8'b00100000,
        S_POP      = 8'b01000000,
        S_RESP     = 8'b10000000
    } state_t;

    state_t               state_reg, state_next;
    in_t                  req_reg, req_next;
    out_t                 res_reg, res_next;
    logic [MOVE_BITS-1:0] moved_reg, moved_next;
    logic                 m_valid_reg, m_valid_next;
    out_t                 m_data_reg, m_data_next;

    heap_cmd_t        w_cmd, r_cmd;
    logic [WDW-1:0]   w_push, w_root;
    logic [RDW-1:0]   r_push, r_root;
    logic             w_done, r_done;
    logic [CW-1:0]    w_cnt, r_cnt;

    rtdq_heap #(.DEPTH(HEAP_DEPTH), .DW(WDW), .KW(TIME_BITS)) u_wait_heap (
        .aclk(aclk), .aresetn(aresetn), .cmd(w_cmd), .push_data(w_push),
        .done(w_done), .root(w_root), .count(w_cnt)
    );

    rtdq_heap #(.DEPTH(HEAP_DEPTH), .DW(RDW), .KW(TIME_BITS)) u_ready_heap (
        .aclk(aclk), .aresetn(aresetn), .cmd(r_cmd), .push_data(r_push),
        .done(r_done), .root(r_root), .count(r_cnt)
    );

    assign w_push = {ID_BITS'(req_reg.task_id), req_reg.deadline, req_reg.release_time};
    assign r_push = {w_root[WDW-1:2*TIME_BITS], w_root[2*TIME_BITS-1:TIME_BITS]};

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        moved_next   = moved_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        w_cmd        = '{valid: 1'b0, op: HOP_PEEK};
        r_cmd        = '{valid: 1'b0, op: HOP_PEEK};
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    res_next   = '0;
                    moved_next = '0;
                    case (s_data.req_type)
                        REQ_INSERT: begin
                            if (w_cnt < FULL_LVL) begin
                                state_next = S_INS;
                            end else begin
                                res_next.status = ST_FULL;
                                state_next      = S_RESP;
                            end
                        end
                        REQ_UPDATE: begin
                            state_next = S_UPD_CHK;
                        end
                        REQ_POP: begin
                            if (r_cnt == '0) begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_RESP;
                            end else begin
                                r_cmd      = '{valid: 1'b1, op: HOP_POP};
                                state_next = S_POP;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_INS: begin
                w_cmd = '{valid: !w_done, op: HOP_PUSH};
                if (w_done) begin
                    state_next = S_RESP;
                end
            end
            S_UPD_CHK: begin
                if (r_cnt < FULL_LVL && w_cnt != '0) begin
                    w_cmd      = '{valid: 1'b1, op: HOP_PEEK};
                    state_next = S_UPD_PK;
                end else begin
                    res_next.moved_count = moved_reg;
                    state_next           = S_RESP;
                end
            end
            S_UPD_PK: begin
                if (w_done) begin
                    if (w_root[TIME_BITS-1:0] <= req_reg.now_time) begin
                        w_cmd      = '{valid: 1'b1, op: HOP_POP};
                        state_next = S_UPD_POP;
                    end else begin
                        res_next.moved_count = moved_reg;
                        state_next           = S_RESP;
                    end
                end
            end
            S_UPD_POP: begin
                if (w_done) begin
                    r_cmd      = '{valid: 1'b1, op: HOP_PUSH};
                    state_next = S_UPD_PUSH;
                end
            end
            S_UPD_PUSH: begin
                if (r_done) begin
                    if (moved_reg != '1) begin
                        moved_next = moved_reg + MOVE_BITS'(1);
                    end
                    state_next = S_UPD_CHK;
                end
            end
            S_POP: begin
                if (r_done) begin
                    res_next.out_task_id  = OUT_ID_BITS'(r_root[RDW-1:TIME_BITS]);
                    res_next.out_deadline = r_root[TIME_BITS-1:0];
                    state_next            = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        moved_reg  <= moved_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // heap fill levels stay below the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        w_cnt <= FULL_LVL && r_cnt <= FULL_LVL)
        else $error("heap count above limit");

    // a request is taken only once per pass through idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted twice");

    // ready heap grows or shrinks by one task at most
    assert property (@(posedge aclk) disable iff (!aresetn)
        (r_cnt != $past(r_cnt)) |->
            (r_cnt == $past(r_cnt) + CW'(1) || r_cnt == $past(r_cnt) - CW'(1)))
        else $error("ready count jumped");

    // wait heap only answers while the core is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        w_done |-> state_reg != S_IDLE && state_reg != S_RESP)
        else $error("stray wait heap completion");

endmodule

FILE: test/release_and_deadline_task_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// release_and_deadline_task_queue_core_tb
// self-checking bench: directed and random insert, update and pop requests
// against a behavioural model of both heaps, with random stalls on each side
// ----------------------------------------------------------------------------
module release_and_deadline_task_queue_core_tb;
    import rtdq_pkg::*;

    localparam int DEPTH = HEAP_DEPTH_DEF;
    localparam int LIMIT = DEPTH - 1;
    localparam logic [62:0] TMAX = {63{1'b1}};
    localparam logic [1:0] REQ_SPARE = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic s_fire = 1'b0;
    logic start_hold = 1'b0;
    logic hold_on = 1'b0;

    release_and_deadline_task_queue_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // model heaps
    logic [15:0] w_id [DEPTH];
    logic [62:0] w_rel [DEPTH];
    logic [62:0] w_dl [DEPTH];
    int w_n = 0;
    logic [15:0] r_id [DEPTH];
    logic [62:0] r_dl [DEPTH];
    int r_n = 0;

    in_t pending_reqs[$];
    out_t expected_results[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int n_pops = 0, n_moves = 0, n_full = 0, n_empty = 0;

    initial forever #2 aclk = ~aclk;

    task automatic wait_insert(logic [15:0] id, logic [62:0] rel, logic [62:0] dl);
        int i;
        int p;
        i = w_n;
        w_id[i] = id; w_rel[i] = rel; w_dl[i] = dl;
        w_n++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (w_rel[p] > w_rel[i]) begin
                {w_id[p], w_id[i]} = {w_id[i], w_id[p]};
                {w_rel[p], w_rel[i]} = {w_rel[i], w_rel[p]};
                {w_dl[p], w_dl[i]} = {w_dl[i], w_dl[p]};
                i = p;
            end else break;
        end
    endtask

    task automatic ready_insert(logic [15:0] id, logic [62:0] dl);
        int i;
        int p;
        i = r_n;
        r_id[i] = id; r_dl[i] = dl;
        r_n++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (r_dl[p] > r_dl[i]) begin
                {r_id[p], r_id[i]} = {r_id[i], r_id[p]};
                {r_dl[p], r_dl[i]} = {r_dl[i], r_dl[p]};
                i = p;
            end else break;
        end
    endtask

    task automatic wait_remove_root();
        int i, l, r, s;
        i = 0;
        w_n--;
        w_id[0] = w_id[w_n]; w_rel[0] = w_rel[w_n]; w_dl[0] = w_dl[w_n];
        forever begin
            l = 2 * i + 1; r = 2 * i + 2; s = i;
            if (l < w_n && w_rel[s] > w_rel[l]) s = l;
            if (r < w_n && w_rel[s] > w_rel[r]) s = r;
            if (s == i) break;
            {w_id[s], w_id[i]} = {w_id[i], w_id[s]};
            {w_rel[s], w_rel[i]} = {w_rel[i], w_rel[s]};
            {w_dl[s], w_dl[i]} = {w_dl[i], w_dl[s]};
            i = s;
        end
    endtask

    task automatic ready_remove_root();
        int i, l, r, s;
        i = 0;
        r_n--;
        r_id[0] = r_id[r_n]; r_dl[0] = r_dl[r_n];
        forever begin
            l = 2 * i + 1; r = 2 * i + 2; s = i;
            if (l < r_n && r_dl[s] > r_dl[l]) s = l;
            if (r < r_n && r_dl[s] > r_dl[r]) s = r;
            if (s == i) break;
            {r_id[s], r_id[i]} = {r_id[i], r_id[s]};
            {r_dl[s], r_dl[i]} = {r_dl[i], r_dl[s]};
            i = s;
        end
    endtask

    // schedule model: one result per request, all zero for the unused code
    task automatic schedule_request(in_t q);
        out_t o;
        logic [15:0] id;
        logic [62:0] dl;
        o = '0;
        case (q.req_type)
            REQ_INSERT: begin
                if (w_n < LIMIT) wait_insert(q.task_id, q.release_time, q.deadline);
                else begin
                    o.status = ST_FULL;
                    n_full++;
                end
            end
            REQ_UPDATE: begin
                while (r_n < LIMIT && w_n > 0 && w_rel[0] <= q.now_time) begin
                    id = w_id[0]; dl = w_dl[0];
                    wait_remove_root();
                    ready_insert(id, dl);
                    if (o.moved_count != 8'hFF) o.moved_count++;
                    n_moves++;
                end
            end
            REQ_POP: begin
                if (r_n == 0) begin
                    o.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    o.out_task_id = r_id[0];
                    o.out_deadline = r_dl[0];
                    ready_remove_root();
                    n_pops++;
                end
            end
            default: ;
        endcase
        expected_results.push_back(o);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic in_t make_req(logic [1:0] t, logic [62:0] tlo, logic [62:0] thi);
        in_t q;
        q.req_type = t;
        q.task_id = 16'($urandom);
        q.release_time = tlo + 63'({$urandom, $urandom} % (thi - tlo + 1));
        q.deadline = tlo + 63'({$urandom, $urandom} % (thi - tlo + 1));
        q.now_time = tlo + 63'({$urandom, $urandom} % (thi - tlo + 1));
        return q;
    endfunction

    // acceptance seen at the rising edge
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) begin
                schedule_request(s_data);
            end
            if (!s_valid || s_fire) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_on) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // long receiver hold-off
    initial begin
        wait (start_hold);
        hold_on = 1'b1;
        repeat (3000) @(negedge aclk);
        hold_on = 1'b0;
    end

    // monitor
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_data.out_deadline), 64'(0));
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", 64'(m_data.status), 64'(want.status));
                if (m_data.out_task_id !== want.out_task_id)
                    report_mismatch("out_task_id", 64'(m_data.out_task_id),
                                    64'(want.out_task_id));
                if (m_data.out_deadline !== want.out_deadline)
                    report_mismatch("out_deadline", 64'(m_data.out_deadline),
                                    64'(want.out_deadline));
                if (m_data.moved_count !== want.moved_count)
                    report_mismatch("moved_count", 64'(m_data.moved_count),
                                    64'(want.moved_count));
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic push_req(logic [1:0] t, logic [15:0] id, logic [62:0] rel,
                            logic [62:0] dl, logic [62:0] now);
        in_t q;
        q.req_type = t; q.task_id = id; q.release_time = rel;
        q.deadline = dl; q.now_time = now;
        pending_reqs.push_back(q);
    endtask

    // random traffic within a time window, biased to the given mix, plus about two percent unused-code requests
    task automatic random_phase(int n, int ins_pct, int upd_pct, logic [62:0] thi);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                pending_reqs.push_back(make_req(REQ_SPARE, 0, TMAX));
            else if (r < ins_pct)
                pending_reqs.push_back(make_req(REQ_INSERT, 0, thi));
            else if (r < ins_pct + upd_pct)
                pending_reqs.push_back(make_req(REQ_UPDATE, 0, thi));
            else
                pending_reqs.push_back(make_req(REQ_POP, 0, thi));
        end
    endtask

    initial begin
        int k;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty pop, extremes, equal keys, unused code
        push_req(REQ_POP, 16'h0, 0, 0, 0);
        push_req(REQ_UPDATE, 16'h0, 0, 0, TMAX);
        push_req(REQ_INSERT, 16'hFFFF, TMAX, TMAX, 0);
        push_req(REQ_INSERT, 16'h0000, 0, 0, TMAX);
        push_req(REQ_INSERT, 16'h5555, 10, 7, 0);
        push_req(REQ_INSERT, 16'hAAAA, 10, 7, 0);
        push_req(REQ_UPDATE, 16'h0, 0, 0, 9);
        push_req(REQ_UPDATE, 16'h0, 0, 0, 10);
        push_req(REQ_SPARE, 16'hFFFF, TMAX, TMAX, TMAX);
        push_req(REQ_POP, 16'h0, 0, 0, 0);
        push_req(REQ_POP, 16'h0, 0, 0, 0);
        push_req(REQ_UPDATE, 16'h0, 0, 0, TMAX - 1);
        push_req(REQ_UPDATE, 16'h0, 0, 0, TMAX);
        push_req(REQ_POP, 16'h0, 0, 0, 0);
        push_req(REQ_POP, 16'h0, 0, 0, 0);
        push_req(REQ_POP, 16'h0, 0, 0, 0);
        drain();

        // fill the wait heap past full, long receiver hold-off meanwhile
        start_hold = 1'b1;
        for (k = 0; k < LIMIT + 3; k++)
            pending_reqs.push_back(make_req(REQ_INSERT, 0, 1000));
        push_req(REQ_UPDATE, 0, 0, 0, TMAX);
        for (k = 0; k < LIMIT + 1; k++)
            pending_reqs.push_back(make_req(REQ_INSERT, 0, 1000));
        push_req(REQ_UPDATE, 0, 0, 0, TMAX);
        for (k = 0; k < 40; k++) push_req(REQ_POP, 0, 0, 0, 0);
        push_req(REQ_UPDATE, 0, 0, 0, TMAX);
        for (k = 0; k < LIMIT + 2; k++) push_req(REQ_POP, 0, 0, 0, 0);
        for (k = 0; k < LIMIT; k++)
            pending_reqs.push_back(make_req(REQ_INSERT, 0, 100));
        drain();

        send_idle = 16; recv_idle = 79;
        random_phase(250, 45, 20, 1000);
        random_phase(50, 40, 20, TMAX);
        drain();
        send_idle = 79; recv_idle = 16;
        random_phase(250, 40, 25, 1000);
        drain();
        send_idle = 0; recv_idle = 0;
        random_phase(200, 35, 25, 1000);
        random_phase(50, 40, 20, TMAX);
        drain();

        $display("covered %0d pops, %0d moved tasks, %0d full and %0d empty answers",
                 n_pops, n_moves, n_full, n_empty);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("release_and_deadline_task_queue_core verification clean");
        end else begin
            $display("release_and_deadline_task_queue_core verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("release_and_deadline_task_queue_core verification failed");
        $finish;
    end

endmodule
